[hdl/ltpe_pkg.sv]
// Package for the lobed torus point evaluator: types, constants, helpers.
package ltpe_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int REG_W          = 16;
   localparam int OUT_W          = 19;
   localparam int Q30_W          = 32;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [REG_W-1:0] MAJOR_RESET = 16'd6144;
   localparam logic [REG_W-1:0] MINOR_RESET = 16'd2048;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAJOR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MINOR = 3'd4;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Taylor divisors, innermost first: sine then cosine.
   localparam int NSTEP = 4;
   localparam int SIN_DIV [NSTEP] = '{72, 42, 20, 6};
   localparam int COS_DIV [NSTEP] = '{56, 30, 12, 2};

   // Number of trig cells in the chain: phase reduction to x, x2, first Horner divide,
   // three multiply/divide cell pairs, sine product.
   localparam int TRIG_LAT = 10;

   // Floor of a / Dv for a constant Dv, by a multiply with the rounded-up reciprocal.
   // The shift of 31 plus the ceiling of log2 of the divisor keeps it exact for any 31-bit a.
   function automatic logic [30:0] div_const(input logic [30:0] a, input int unsigned Dv);
      int unsigned sh;
      logic [32:0] m;
      logic [63:0] prod;
      begin
         sh   = 31 + $clog2(Dv);
         m    = 33'(((64'd1 << sh) + 64'(Dv) - 64'd1) / 64'(Dv));
         prod = 64'(a) * 64'(m);
         return 31'(prod >> sh);
      end
   endfunction

   typedef struct packed {
      logic        oct_sw;
      logic        neg_s;
      logic        neg_c;
   } fold_type;

   typedef struct packed {
      logic [30:0] x;
      logic [30:0] x2;
      logic [30:0] s;
      logic [30:0] c;
      logic [30:0] ps;
      logic [30:0] pc;
      fold_type    fold;
   } trig_type;

endpackage

[hdl/ltpe_trig_cell.sv]
// One cell of the sine/cosine chain; STAGE selects which step it performs.
module ltpe_trig_cell #(
   parameter int STAGE = 0,
   parameter int ANGLE_BITS = ltpe_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] phase,
   input  ltpe_pkg::trig_type    prev,
   output ltpe_pkg::trig_type    next
);
   import ltpe_pkg::*;

   // Horner step that a divide cell works on.
   localparam int HSTEP = (STAGE >= 2 && STAGE <= 9) ? (STAGE - 2) / 2 : 0;

   ltpe_pkg::trig_type next_ff, next_in;
   logic [31:0] p;
   logic [2:0]  oct;
   logic [29:0] t;
   logic [63:0] prod;

   // Each cell computes one step and hands the bundle to its neighbor.
   always_comb begin
      next_in = prev;
      p    = 32'(phase) << (32 - ANGLE_BITS);
      oct  = p[31:29];
      t    = oct[0] ? (30'h2000_0000 - {1'b0, p[28:0]}) : {1'b0, p[28:0]};
      prod = '0;
      case (STAGE)
         0: begin
            prod = 64'(t) * 64'(PI_Q30);
            next_in.x = 31'(prod >> 31);
            next_in.fold.oct_sw = oct[1] ^ oct[0];
            next_in.fold.neg_s  = oct[2];
            next_in.fold.neg_c  = (oct >= 3'd2) && (oct <= 3'd5);
         end
         1: begin
            prod = 64'(prev.x) * 64'(prev.x);
            next_in.x2 = 31'(prod >> 30);
         end
         2: begin
            next_in.s = Q30_ONE - div_const(prev.x2, SIN_DIV[HSTEP]);
            next_in.c = Q30_ONE - div_const(prev.x2, COS_DIV[HSTEP]);
         end
         // Multiply half of a Horner step.
         3, 5, 7: begin
            prod = 64'(prev.x2) * 64'(prev.s);
            next_in.ps = 31'(prod >> 30);
            prod = 64'(prev.x2) * 64'(prev.c);
            next_in.pc = 31'(prod >> 30);
         end
         // Divide half of a Horner step.
         4, 6, 8: begin
            next_in.s = Q30_ONE - div_const(prev.ps, SIN_DIV[HSTEP]);
            next_in.c = Q30_ONE - div_const(prev.pc, COS_DIV[HSTEP]);
         end
         9: begin
            prod = 64'(prev.x) * 64'(prev.s);
            next_in.s = 31'(prod >> 30);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;
endmodule

[hdl/ltpe_sincos.sv]
// Chain of trig cells giving signed Q30 sine and cosine of a phase.
module ltpe_sincos #(
   parameter int ANGLE_BITS = ltpe_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] phase,
   output logic signed [32:0]    sin_q30,
   output logic signed [32:0]    cos_q30
);
   import ltpe_pkg::*;

   localparam int NCELL = TRIG_LAT;
   trig_type chain [NCELL+1];
   logic signed [32:0] sin_ff, cos_ff, sin_in, cos_in;
   logic [30:0] a, b;

   assign chain[0] = '0;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      ltpe_trig_cell #(.STAGE(g), .ANGLE_BITS(ANGLE_BITS)) u_cell (
         .clock  (clock),
         .enable (enable),
         .phase  (phase),
         .prev   (chain[g]),
         .next   (chain[g+1])
      );
   end

   // Octant fold: swap and negate.
   always_comb begin
      a = chain[NCELL].s;
      b = chain[NCELL].c;
      sin_in = chain[NCELL].fold.oct_sw ? 33'(b) : 33'(a);
      cos_in = chain[NCELL].fold.oct_sw ? 33'(a) : 33'(b);
      if (chain[NCELL].fold.neg_s) sin_in = -sin_in;
      if (chain[NCELL].fold.neg_c) cos_in = -cos_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q30 = sin_ff;
   assign cos_q30 = cos_ff;
endmodule

[hdl/lobed_torus_point_eval.sv]
// Top level: lobed torus surface point from a (u, v) phase pair.
// An item passes 15 registers: ten trig cells, the octant fold, three combine stages, the output.
// Throughput: one item per cycle; the chain advances whenever the output register is free
// or being taken, so it stalls only while an untaken result waits.
// Reset (synchronous, active high) clears valid bits and loads R = 1.5, r = 0.5.
module lobed_torus_point_eval #(
   parameter int ANGLE_BITS = ltpe_pkg::ANGLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // u_angle [15:0], v_angle [31:16]
   input  logic [((2*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // x_pos [18:0], y_pos [37:19], z_pos [56:38], zero fill
   output logic [63:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ltpe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import ltpe_pkg::*;

   localparam int LAT = TRIG_LAT + 1 + 4;
   localparam int SH_R = 30 - 14;

   logic [REG_W-1:0] major_ff, minor_ff;
   logic [LAT-1:0] vld_ff, vld_in;
   logic adv;
   logic [ANGLE_BITS-1:0] u_a, v_a, v3_a;
   logic signed [32:0] su, cu, sv, cv, s3, c3;

   // Configuration registers.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= MAJOR_RESET;
         minor_ff <= MINOR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == ADDR_MAJOR) major_ff <= csr_pwdata[REG_W-1:0];
         if (csr_paddr == ADDR_MINOR) minor_ff <= csr_pwdata[REG_W-1:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_MAJOR) csr_prdata = 32'(major_ff);
      else if (csr_paddr == ADDR_MINOR) csr_prdata = 32'(minor_ff);
   end

   // Pipeline advance: stall only when the output holds an untaken item.
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign u_a  = req_tdata[ANGLE_BITS-1:0];
   assign v_a  = req_tdata[ANGLE_BITS +: ANGLE_BITS];
   assign v3_a = ANGLE_BITS'(3 * v_a);

   ltpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_su (.clock(clock), .enable(adv),
      .phase(u_a), .sin_q30(su), .cos_q30(cu));
   ltpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sv (.clock(clock), .enable(adv),
      .phase(v_a), .sin_q30(sv), .cos_q30(cv));
   ltpe_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_s3 (.clock(clock), .enable(adv),
      .phase(v3_a), .sin_q30(s3), .cos_q30(c3));

   // Stage A: lobe and height sums, carry sine/cosine of u.
   logic signed [35:0] lobe_ff, height_ff;
   logic signed [32:0] su_a_ff, cu_a_ff;
   // Stage B: ring in Q(F+30) and y rounded.
   logic signed [55:0] ring_ff, ring_in;
   logic signed [55:0] ys_prod;
   logic signed [OUT_W-1:0] y_b_ff, y_c_ff;
   logic signed [32:0] su_b_ff, cu_b_ff;
   // Stage C: ring rounded to Q(F+14).
   logic signed [40:0] rr_ff, rr_in;
   logic signed [32:0] su_c_ff, cu_c_ff;
   // Output register.
   logic signed [74:0] xp, zp;
   logic signed [OUT_W-1:0] x_in, z_in, x_ff, z_ff, y_ff;

   always_comb begin
      ring_in = $signed(56'(major_ff) << 30) + $signed({1'b0, minor_ff}) * lobe_ff;
      ys_prod = $signed({1'b0, minor_ff}) * height_ff + (56'sd1 <<< 29);
      rr_in   = 41'((ring_ff + (56'sd1 <<< (SH_R-1))) >>> SH_R);
      xp      = rr_ff * cu_c_ff + (75'sd1 <<< 43);
      zp      = rr_ff * su_c_ff + (75'sd1 <<< 43);
      x_in    = OUT_W'(xp >>> 44);
      z_in    = OUT_W'(zp >>> 44);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lobe_ff   <= 36'(3 * 36'(cv)) - 36'(c3);
         height_ff <= 36'(3 * 36'(sv)) - 36'(s3);
         su_a_ff <= su; cu_a_ff <= cu;
         ring_ff <= ring_in;
         y_b_ff  <= OUT_W'(ys_prod >>> 30);
         su_b_ff <= su_a_ff; cu_b_ff <= cu_a_ff;
         rr_ff   <= rr_in;
         y_c_ff  <= y_b_ff;
         su_c_ff <= su_b_ff; cu_c_ff <= cu_b_ff;
         x_ff <= x_in; z_ff <= z_in; y_ff <= y_c_ff;
      end
   end

   // Valid bits ride beside the data.
   always_comb vld_in = {vld_ff[LAT-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'd0, z_ff, y_ff, x_ff};

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   // Ready follows the output register.
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted during stall");
   // A write to the major-radius register lands.
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_MAJOR
      |=> major_ff == $past(csr_pwdata[REG_W-1:0]))
      else $error("register write lost");
endmodule
